FILE: src/aam_pkg.sv
// Shared types, codes and helpers of the admittance matrix builder.
// No dependencies; compiled first.
`default_nettype none
package aam_pkg;
  localparam int BUS_COUNT_DEF = 64;
  localparam int BUS_W = 6;
  localparam int LINE_W = 32;
  localparam int ENTRY_W = 48;
  localparam int DIV_STEPS = 80;
  localparam int QUO_W = 57;
  localparam int DEN_W = 64;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_ADD = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
  localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

  typedef enum logic [2:0] {OP_CLEAR, OP_ADD, OP_READ, OP_ZERO, OP_NOP} op_t;

  typedef struct packed {
    op_t op;
    logic [BUS_W-1:0] bus_a;
    logic [BUS_W-1:0] bus_b;
    logic [LINE_W-1:0] r_mag;
    logic [LINE_W-1:0] x_mag;
    logic re_neg;
    logic im_neg;
    logic signed [LINE_W-1:0] half;
  } cmd_t;

  function automatic logic [ENTRY_W-1:0] sat_entry(input logic signed [ENTRY_W+2:0] v);
    logic ovf;
    ovf = (v[ENTRY_W+2:ENTRY_W-1] != {4{v[ENTRY_W+2]}});
    if (!ovf) return v[ENTRY_W-1:0];
    return v[ENTRY_W+2] ? ENTRY_MIN : ENTRY_MAX;
  endfunction
endpackage
`default_nettype wire

FILE: src/aam_in_if.sv
// Input channel of the admittance matrix builder.
// Depends on aam_pkg.
`default_nettype none
interface aam_in_if;
  logic valid;
  logic ready;
  logic [1:0] mode;
  logic [aam_pkg::BUS_W-1:0] bus_a;
  logic [aam_pkg::BUS_W-1:0] bus_b;
  logic signed [aam_pkg::LINE_W-1:0] resistance;
  logic signed [aam_pkg::LINE_W-1:0] reactance;
  logic signed [aam_pkg::LINE_W-1:0] charging;
  modport source (output valid, mode, bus_a, bus_b, resistance, reactance, charging,
                  input ready);
  modport sink (input valid, mode, bus_a, bus_b, resistance, reactance, charging,
                output ready);
endinterface
`default_nettype wire

FILE: src/aam_out_if.sv
// Result channel of the admittance matrix builder.
// Depends on aam_pkg.
`default_nettype none
interface aam_out_if;
  logic valid;
  logic ready;
  logic signed [aam_pkg::ENTRY_W-1:0] entry_real;
  logic signed [aam_pkg::ENTRY_W-1:0] entry_imag;
  logic [1:0] status;
  modport source (output valid, entry_real, entry_imag, status, input ready);
  modport sink (input valid, entry_real, entry_imag, status, output ready);
endinterface
`default_nettype wire

FILE: src/aam_front.sv
// Front end: accepts input transfers and classifies them into commands.
// Depends on aam_pkg and aam_in_if.
`default_nettype none
module aam_front #(
  parameter int BUS_COUNT = aam_pkg::BUS_COUNT_DEF
) (
  aam_in_if.sink in_ch,
  input logic q_full,
  input logic init_busy,
  output logic push,
  output aam_pkg::cmd_t cmd
);
  import aam_pkg::*;

  logic in_range;
  logic signed [LINE_W-1:0] ch_adj;

  assign in_ch.ready = !q_full && !init_busy;
  assign push = in_ch.valid && in_ch.ready;

  always_comb begin
    in_range = ({3'b0, in_ch.bus_a} < 9'(BUS_COUNT)) && ({3'b0, in_ch.bus_b} < 9'(BUS_COUNT));
    ch_adj = in_ch.charging + $signed({{(LINE_W-1){1'b0}}, in_ch.charging[LINE_W-1]});
    cmd.bus_a = in_ch.bus_a;
    cmd.bus_b = in_ch.bus_b;
    cmd.r_mag = in_ch.resistance[LINE_W-1] ? (~in_ch.resistance + 1'b1) : in_ch.resistance;
    cmd.x_mag = in_ch.reactance[LINE_W-1] ? (~in_ch.reactance + 1'b1) : in_ch.reactance;
    cmd.re_neg = in_ch.resistance[LINE_W-1];
    cmd.im_neg = !in_ch.reactance[LINE_W-1] && (in_ch.reactance != '0);
    cmd.half = ch_adj >>> 1;
    unique case (in_ch.mode)
      MODE_CLEAR: cmd.op = OP_CLEAR;
      MODE_ADD: begin
        if (!in_range) cmd.op = OP_NOP;
        else if (in_ch.resistance == '0 && in_ch.reactance == '0) cmd.op = OP_ZERO;
        else cmd.op = OP_ADD;
      end
      MODE_READ: cmd.op = in_range ? OP_READ : OP_NOP;
      default: cmd.op = OP_NOP;
    endcase
  end
endmodule
`default_nettype wire

FILE: src/aam_queue.sv
// Two-entry command queue between front and back.
// Depends on aam_pkg.
`default_nettype none
module aam_queue (
  input logic clk,
  input logic rst_n,
  input logic push,
  input aam_pkg::cmd_t push_cmd,
  input logic pop,
  output logic full,
  output logic not_empty,
  output aam_pkg::cmd_t head
);
  import aam_pkg::*;

  cmd_t slot_r [2];
  logic wr_ptr_r;
  logic rd_ptr_r;
  logic [1:0] count_r;

  assign full = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign head = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_cmd;
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: src/aam_back.sv
// Back end: complex reciprocal by bit-serial division, matrix store with
// read-modify-write, clearing sweep and result register. Depends on aam_pkg, aam_out_if.
`default_nettype none
module aam_back #(
  parameter int BUS_COUNT = aam_pkg::BUS_COUNT_DEF
) (
  input logic clk,
  input logic rst_n,
  input aam_pkg::cmd_t cmd,
  input logic cmd_valid,
  output logic cmd_pop,
  output logic init_busy,
  aam_out_if.source out_ch
);
  import aam_pkg::*;

  localparam int DEPTH = BUS_COUNT * BUS_COUNT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DIV_STEPS + 1);
  localparam logic [QUO_W-1:0] QCAP = QUO_W'(1) << (QUO_W - 1);
  localparam logic [QUO_W-1:0] QHALF = QUO_W'(1) << (ENTRY_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_CLR, S_MUL, S_SUM, S_DIV, S_FIN, S_RMW_RD, S_RMW_WR, S_RD_ISSUE, S_RD_DATA
  } state_t;

  state_t state_r;
  logic clr_out_r;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [1:0] step_r;
  logic [LINE_W-1:0] mag_r [2];
  logic [DEN_W-1:0] prod_r [2];
  logic [DEN_W-1:0] rem_r [2];
  logic [QUO_W-1:0] q_r [2];
  logic neg_r [2];
  logic signed [ENTRY_W-1:0] ys_r [2];
  logic signed [LINE_W-1:0] half_r;
  logic [DEN_W-1:0] den_r;
  logic sat_r;
  logic [ADDR_W-1:0] addr_r [4];
  logic out_valid_r;
  logic signed [ENTRY_W-1:0] out_re_r;
  logic signed [ENTRY_W-1:0] out_im_r;
  logic [1:0] out_st_r;

  logic signed [ENTRY_W-1:0] re_mem [DEPTH];
  logic signed [ENTRY_W-1:0] im_mem [DEPTH];
  logic signed [ENTRY_W-1:0] rd_re_r;
  logic signed [ENTRY_W-1:0] rd_im_r;

  logic mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [ADDR_W-1:0] mem_ra;
  logic signed [ENTRY_W-1:0] mem_wre;
  logic signed [ENTRY_W-1:0] mem_wim;

  logic [DEN_W-1:0] rem_nxt [2];
  logic [QUO_W-1:0] q_nxt [2];
  logic signed [ENTRY_W-1:0] ys_nxt [2];
  logic fin_ovf;
  logic signed [ENTRY_W+1:0] d_re;
  logic signed [ENTRY_W+1:0] d_im;
  logic signed [ENTRY_W+2:0] sum_re;
  logic signed [ENTRY_W+2:0] sum_im;
  logic acc_ovf;
  logic [ADDR_W-1:0] a_row;
  logic [ADDR_W-1:0] b_row;

  assign cmd_pop = (state_r == S_IDLE) && cmd_valid && !out_valid_r;
  assign init_busy = (state_r == S_CLR) && !clr_out_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.entry_real = out_re_r;
  assign out_ch.entry_imag = out_im_r;
  assign out_ch.status = out_st_r;

  always_comb begin
    logic [DEN_W:0] rem_sh;
    logic [QUO_W:0] q_sh;
    logic ge;
    fin_ovf = 1'b0;
    for (int l = 0; l < 2; l++) begin
      rem_sh = {rem_r[l], mag_r[l][LINE_W-1]};
      ge = (rem_sh >= {1'b0, den_r});
      rem_nxt[l] = ge ? DEN_W'(rem_sh - {1'b0, den_r}) : rem_sh[DEN_W-1:0];
      q_sh = {q_r[l], ge};
      q_nxt[l] = (q_sh >= (QUO_W+1)'(QCAP)) ? QCAP : q_sh[QUO_W-1:0];
      if (neg_r[l]) begin
        if (q_r[l] > QHALF) begin
          ys_nxt[l] = ENTRY_MIN;
          fin_ovf = 1'b1;
        end else begin
          ys_nxt[l] = -$signed(q_r[l][ENTRY_W-1:0]);
        end
      end else begin
        if (q_r[l] >= QHALF) begin
          ys_nxt[l] = ENTRY_MAX;
          fin_ovf = 1'b1;
        end else begin
          ys_nxt[l] = $signed(q_r[l][ENTRY_W-1:0]);
        end
      end
    end
  end

  always_comb begin
    if (step_r[1]) begin
      d_re = -(ENTRY_W+2)'(ys_r[0]);
      d_im = -(ENTRY_W+2)'(ys_r[1]);
    end else begin
      d_re = (ENTRY_W+2)'(ys_r[0]);
      d_im = (ENTRY_W+2)'(ys_r[1]) + (ENTRY_W+2)'(half_r);
    end
    sum_re = (ENTRY_W+3)'(rd_re_r) + (ENTRY_W+3)'(d_re);
    sum_im = (ENTRY_W+3)'(rd_im_r) + (ENTRY_W+3)'(d_im);
    acc_ovf = (sum_re[ENTRY_W+2:ENTRY_W-1] != {4{sum_re[ENTRY_W+2]}})
           || (sum_im[ENTRY_W+2:ENTRY_W-1] != {4{sum_im[ENTRY_W+2]}});
    a_row = ADDR_W'(ADDR_W'(cmd.bus_a) * ADDR_W'(BUS_COUNT));
    b_row = ADDR_W'(ADDR_W'(cmd.bus_b) * ADDR_W'(BUS_COUNT));
    mem_ra = addr_r[step_r];
    mem_we = 1'b0;
    mem_wa = addr_r[step_r];
    mem_wre = '0;
    mem_wim = '0;
    if (state_r == S_CLR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr_r;
    end else if (state_r == S_RMW_WR) begin
      mem_we = 1'b1;
      mem_wre = sat_entry(sum_re);
      mem_wim = sat_entry(sum_im);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      re_mem[mem_wa] <= mem_wre;
      im_mem[mem_wa] <= mem_wim;
    end
    rd_re_r <= re_mem[mem_ra];
    rd_im_r <= im_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_out_r <= 1'b0;
      clr_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_pop) begin
            out_re_r <= '0;
            out_im_r <= '0;
            out_st_r <= (cmd.op == OP_ZERO) ? ST_ZERO : ST_OK;
            mag_r[0] <= cmd.r_mag;
            mag_r[1] <= cmd.x_mag;
            neg_r[0] <= cmd.re_neg;
            neg_r[1] <= cmd.im_neg;
            half_r <= cmd.half;
            sat_r <= 1'b0;
            step_r <= 2'd0;
            addr_r[0] <= (cmd.op == OP_READ) ? (a_row + ADDR_W'(cmd.bus_b))
                                             : (a_row + ADDR_W'(cmd.bus_a));
            addr_r[1] <= b_row + ADDR_W'(cmd.bus_b);
            addr_r[2] <= a_row + ADDR_W'(cmd.bus_b);
            addr_r[3] <= b_row + ADDR_W'(cmd.bus_a);
            priority case (cmd.op)
              OP_CLEAR: begin
                clr_out_r <= 1'b1;
                clr_addr_r <= '0;
                state_r <= S_CLR;
              end
              OP_ADD: state_r <= S_MUL;
              OP_READ: state_r <= S_RD_ISSUE;
              OP_ZERO: out_valid_r <= 1'b1;
              default: out_valid_r <= 1'b1;
            endcase
          end
        end
        S_CLR: begin
          if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
            state_r <= S_IDLE;
            if (clr_out_r) out_valid_r <= 1'b1;
            clr_out_r <= 1'b0;
          end else begin
            clr_addr_r <= clr_addr_r + 1'b1;
          end
        end
        S_MUL: begin
          prod_r[0] <= DEN_W'(mag_r[0]) * DEN_W'(mag_r[0]);
          prod_r[1] <= DEN_W'(mag_r[1]) * DEN_W'(mag_r[1]);
          state_r <= S_SUM;
        end
        S_SUM: begin
          den_r <= prod_r[0] + prod_r[1];
          rem_r[0] <= '0;
          rem_r[1] <= '0;
          q_r[0] <= '0;
          q_r[1] <= '0;
          cnt_r <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          for (int l = 0; l < 2; l++) begin
            rem_r[l] <= rem_nxt[l];
            q_r[l] <= q_nxt[l];
            mag_r[l] <= mag_r[l] << 1;
          end
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          ys_r[0] <= ys_nxt[0];
          ys_r[1] <= ys_nxt[1];
          sat_r <= fin_ovf;
          state_r <= S_RMW_RD;
        end
        S_RMW_RD: state_r <= S_RMW_WR;
        S_RMW_WR: begin
          if (step_r == 2'd3) begin
            out_st_r <= (sat_r || acc_ovf) ? ST_SAT : ST_OK;
            out_valid_r <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            sat_r <= sat_r || acc_ovf;
            step_r <= step_r + 1'b1;
            state_r <= S_RMW_RD;
          end
        end
        S_RD_ISSUE: state_r <= S_RD_DATA;
        S_RD_DATA: begin
          out_re_r <= rd_re_r;
          out_im_r <= rd_im_r;
          out_valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_st_r == ST_ZERO) |-> (out_re_r == '0 && out_im_r == '0))
    else $error("zero impedance result carries nonzero entry");
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divider ran past its step count");
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> !out_valid_r)
    else $error("result raised during reset clearing sweep");
endmodule
`default_nettype wire

FILE: src/admittance_matrix_builder_unit.sv
// Flow: add-line is dominated by the 80-step serial divider, then four read-modify-writes
// (read state, write state); read: issue, then data; clear: a sweep of BUS_COUNT^2 entries.
// Throughput: one item at a time through the back end; a two-entry queue buffers arrivals.
// Reset: synchronous; the store's BUS_COUNT^2 entries are swept to zero while input stalls.
// Top level; depends on aam_pkg, aam_in_if, aam_out_if, aam_front, aam_queue, aam_back.
`default_nettype none
module admittance_matrix_builder_unit #(
  parameter int BUS_COUNT = aam_pkg::BUS_COUNT_DEF
) (
  input logic clk,
  input logic rst_n,
  aam_in_if.sink in_ch,
  aam_out_if.source out_ch
);
  import aam_pkg::*;

  cmd_t push_cmd;
  cmd_t head;
  logic push;
  logic pop;
  logic q_full;
  logic q_not_empty;
  logic init_busy;

  aam_front #(.BUS_COUNT(BUS_COUNT)) u_front (
    .in_ch(in_ch),
    .q_full(q_full),
    .init_busy(init_busy),
    .push(push),
    .cmd(push_cmd)
  );

  aam_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .push_cmd(push_cmd),
    .pop(pop),
    .full(q_full),
    .not_empty(q_not_empty),
    .head(head)
  );

  aam_back #(.BUS_COUNT(BUS_COUNT)) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(head),
    .cmd_valid(q_not_empty),
    .cmd_pop(pop),
    .init_busy(init_busy),
    .out_ch(out_ch)
  );
endmodule
`default_nettype wire
